### hw/rtl/pfb_pkg.sv
// shared constants, opcodes and controller/datapath interface types for the page frame buffer
package pfb_pkg;

   localparam int COLUMNS = 128;
   localparam int ROWS    = 64;

   localparam int PAGES      = (ROWS + 7) / 8;
   localparam int WPP        = (COLUMNS + 7) / 8;
   localparam int DEPTH      = PAGES * WPP;
   localparam int LAST_BYTES = COLUMNS - 8 * (WPP - 1);

   localparam int CXW = $clog2(COLUMNS);
   localparam int YW  = $clog2(ROWS);
   localparam int PGW = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int WCW = (WPP > 1) ? $clog2(WPP) : 1;
   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [1:0] OP_FILL_RECT = 2'd0;
   localparam logic [1:0] OP_FILL_ALL  = 2'd1;
   localparam logic [1:0] OP_FLUSH     = 2'd2;

   localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
   localparam logic [7:0] CMD_COL_LOW   = 8'h00;
   localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
   localparam logic [3:0] CMD_BYTES     = 4'd3;

   typedef struct packed {
      logic load;
      logic screen_fill;
      logic rd;
      logic wr;
      logic advance;
      logic out_cmd;
      logic out_data;
   } pfb_cmd_type;

   typedef struct packed {
      logic empty;
      logic page_ok;
      logic col_end;
      logic page_end;
      logic out_free;
   } pfb_sts_type;

endpackage

### hw/rtl/pfb_ram.sv
// generic single-write, single-read ram with registered read data
module pfb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/pfb_datapath.sv
// frame store, clip bounds, walk counters, read-modify-write and result register
module pfb_datapath import pfb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  pfb_cmd_type        cmd,
   output pfb_sts_type        sts,
   input  logic [1:0]         req_opcode,
   input  logic signed [15:0] req_left_x,
   input  logic signed [15:0] req_top_y,
   input  logic [7:0]         req_rect_width,
   input  logic [7:0]         req_rect_height,
   input  logic               req_color,
   input  logic [2:0]         req_page_index,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic               rsp_is_command,
   output logic [3:0]         rsp_byte_count,
   output logic [63:0]        rsp_packed_bytes,
   output logic               rsp_last
);

   localparam logic signed [16:0] COL_LIM = 17'(COLUMNS);
   localparam logic signed [16:0] ROW_LIM = 17'(ROWS);

   // clip bounds
   logic signed [16:0] xs, xe, ys, ye, x0c, x1c, y0c, y1c;
   logic [CXW-1:0] x_first_in, x_last_in, x_first_ff, x_last_ff;
   logic [YW-1:0]  y_first_in, y_last_in, y_first_ff, y_last_ff;
   logic           empty_in, empty_ff, page_ok_in, page_ok_ff, color_ff;

   // walk counters
   logic [PGW-1:0] page_in, page_ff, page_last_in, page_last_ff;
   logic [WCW-1:0] col_in, col_ff, col_first_in, col_first_ff, col_last_in, col_last_ff;
   logic           col_end, page_end;

   // store
   logic [AW-1:0]    addr;
   logic [DEPTH-1:0] valid_in, valid_ff;
   logic [7:0]       fill_byte_in, fill_byte_ff;
   logic [63:0]      ram_q, old_word, new_word, data_word;

   // masks
   logic [2:0] row_lo, row_hi, col_lo, col_hi;
   logic [7:0] row_mask, byte_en;
   logic [3:0] data_count;

   // result register
   logic        rsp_valid_in, rsp_valid_ff, out_load;
   logic        is_command_in, is_command_ff, last_in, last_ff;
   logic [3:0]  byte_count_in, byte_count_ff;
   logic [63:0] packed_in, packed_ff;

   always_comb begin
      xs  = {req_left_x[15], req_left_x};
      ys  = {req_top_y[15], req_top_y};
      xe  = xs + $signed({9'b0, req_rect_width});
      ye  = ys + $signed({9'b0, req_rect_height});
      x0c = (xs < 17'sd0) ? 17'sd0 : xs;
      y0c = (ys < 17'sd0) ? 17'sd0 : ys;
      x1c = (xe > COL_LIM) ? COL_LIM : xe;
      y1c = (ye > ROW_LIM) ? ROW_LIM : ye;
      empty_in   = (x0c >= x1c) || (y0c >= y1c);
      x_first_in = CXW'(x0c);
      x_last_in  = CXW'(x1c - 17'sd1);
      y_first_in = YW'(y0c);
      y_last_in  = YW'(y1c - 17'sd1);
      page_ok_in = 32'(req_page_index) < PAGES;

      if (req_opcode == OP_FLUSH) begin
         page_in      = PGW'(req_page_index);
         page_last_in = PGW'(req_page_index);
         col_first_in = '0;
         col_last_in  = WCW'(WPP - 1);
      end else begin
         page_in      = PGW'(y_first_in >> 3);
         page_last_in = PGW'(y_last_in >> 3);
         col_first_in = WCW'(x_first_in >> 3);
         col_last_in  = WCW'(x_last_in >> 3);
      end
   end

   assign col_end  = (col_ff == col_last_ff);
   assign page_end = (page_ff == page_last_ff);
   assign addr     = AW'(32'(page_ff) * WPP + 32'(col_ff));

   always_comb begin
      col_in = col_ff;
      if (cmd.load) begin
         col_in = col_first_in;
      end else if (cmd.advance) begin
         col_in = col_end ? col_first_ff : col_ff + 1'b1;
      end
   end

   pfb_ram #(
      .WIDTH (64),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr),
      .wr_addr (addr),
      .wr_data (new_word),
      .rd_en   (cmd.rd),
      .rd_addr (addr),
      .rd_data (ram_q)
   );

   // read-modify-write of one 8-byte word, and the flush data word with bytes past the last column zeroed
   always_comb begin
      old_word = valid_ff[addr] ? ram_q : {8{fill_byte_ff}};
      row_lo   = (page_ff == PGW'(y_first_ff >> 3)) ? y_first_ff[2:0] : 3'd0;
      row_hi   = (page_ff == page_last_ff) ? y_last_ff[2:0] : 3'd7;
      col_lo   = (col_ff == col_first_ff) ? x_first_ff[2:0] : 3'd0;
      col_hi   = (col_ff == col_last_ff) ? x_last_ff[2:0] : 3'd7;
      row_mask = (8'hFF << row_lo) & (8'hFF >> (3'd7 - row_hi));
      byte_en  = (8'hFF << col_lo) & (8'hFF >> (3'd7 - col_hi));
      for (int b = 0; b < 8; b++) begin
         if (byte_en[b]) begin
            new_word[8*b +: 8] = color_ff ? (old_word[8*b +: 8] | row_mask)
                                          : (old_word[8*b +: 8] & ~row_mask);
         end else begin
            new_word[8*b +: 8] = old_word[8*b +: 8];
         end
      end
      data_count = (col_ff == WCW'(WPP - 1)) ? 4'(LAST_BYTES) : 4'd8;
      for (int b = 0; b < 8; b++) begin
         data_word[8*b +: 8] = (4'(b) < data_count) ? old_word[8*b +: 8] : 8'h00;
      end
   end

   always_comb begin
      valid_in     = valid_ff;
      fill_byte_in = fill_byte_ff;
      if (cmd.screen_fill) begin
         valid_in     = '0;
         fill_byte_in = {8{req_color}};
      end else if (cmd.wr) begin
         valid_in[addr] = 1'b1;
      end
   end

   // result register
   always_comb begin
      out_load      = cmd.out_cmd || cmd.out_data;
      rsp_valid_in  = out_load || (rsp_valid_ff && rsp_stall);
      is_command_in = cmd.out_cmd;
      if (cmd.out_cmd) begin
         byte_count_in = CMD_BYTES;
         packed_in     = {40'b0, CMD_COL_HIGH, CMD_COL_LOW, CMD_PAGE_BASE + 8'(page_ff)};
         last_in       = 1'b0;
      end else begin
         byte_count_in = data_count;
         packed_in     = data_word;
         last_in       = col_end;
      end
   end

   assign sts.empty    = empty_ff;
   assign sts.page_ok  = page_ok_ff;
   assign sts.col_end  = col_end;
   assign sts.page_end = page_end;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fill_byte_ff <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         fill_byte_ff <= fill_byte_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
      if (cmd.load) begin
         x_first_ff   <= x_first_in;
         x_last_ff    <= x_last_in;
         y_first_ff   <= y_first_in;
         y_last_ff    <= y_last_in;
         empty_ff     <= empty_in;
         page_ok_ff   <= page_ok_in;
         color_ff     <= req_color;
         page_ff      <= page_in;
         page_last_ff <= page_last_in;
         col_first_ff <= col_first_in;
         col_last_ff  <= col_last_in;
      end else if (cmd.advance && col_end) begin
         page_ff <= page_ff + 1'b1;
      end
      if (out_load) begin
         is_command_ff <= is_command_in;
         byte_count_ff <= byte_count_in;
         packed_ff     <= packed_in;
         last_ff       <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_command   = is_command_ff;
   assign rsp_byte_count   = byte_count_ff;
   assign rsp_packed_bytes = packed_ff;
   assign rsp_last         = last_ff;

endmodule

### hw/rtl/pfb_ctrl.sv
// controller state machine sequencing fills and page flushes
module pfb_ctrl import pfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_opcode,
   output logic        req_stall,
   input  pfb_sts_type sts,
   output pfb_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_FILL_RD = 3'd1;
   localparam logic [2:0] ST_FILL_WR = 3'd2;
   localparam logic [2:0] ST_FL_CMD  = 3'd3;
   localparam logic [2:0] ST_FL_RD   = 3'd4;
   localparam logic [2:0] ST_FL_LD   = 3'd5;

   logic [2:0] state_in, state_ff;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_opcode)
                  OP_FILL_RECT: state_in = ST_FILL_RD;
                  OP_FILL_ALL:  cmd.screen_fill = 1'b1;
                  OP_FLUSH:     state_in = ST_FL_CMD;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_FILL_RD: begin
            if (sts.empty) begin
               state_in = ST_IDLE;
            end else begin
               cmd.rd   = 1'b1;
               state_in = ST_FILL_WR;
            end
         end
         ST_FILL_WR: begin
            cmd.wr = 1'b1;
            if (sts.col_end && sts.page_end) begin
               state_in = ST_IDLE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_FILL_RD;
            end
         end
         ST_FL_CMD: begin
            if (!sts.page_ok) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.out_cmd = 1'b1;
               state_in    = ST_FL_RD;
            end
         end
         ST_FL_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_FL_LD;
         end
         ST_FL_LD: begin
            if (sts.out_free) begin
               cmd.out_data = 1'b1;
               if (sts.col_end) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_FL_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/page_framebuffer_draw_and_scanout.sv
// top level of the page-organized monochrome frame buffer with draw and scanout
//
//  channel  dir  handshake             payload
//  req      in   req_valid/req_stall   opcode, left_x, top_y, rect_width, rect_height,
//                                      color, page_index
//  rsp      out  rsp_valid/rsp_stall   is_command, byte_count, packed_bytes, last
//
// one request at a time; the store is 8-byte words with registered read data
// rectangle fill: a setup step, then a read and a write per store word the clipped rectangle touches
// whole-screen fill: valid bits drop and a fill byte stands in
// page flush: the command word, then a read and a load into the result register per data word
// reset empties the store at once through its valid bits; rsp_stall holds the flush
module page_framebuffer_draw_and_scanout import pfb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic signed [15:0] req_left_x,
   input  logic signed [15:0] req_top_y,
   input  logic [7:0]         req_rect_width,
   input  logic [7:0]         req_rect_height,
   input  logic               req_color,
   input  logic [2:0]         req_page_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_is_command,
   output logic [3:0]         rsp_byte_count,
   output logic [63:0]        rsp_packed_bytes,
   output logic               rsp_last
);

   pfb_cmd_type cmd;
   pfb_sts_type sts;

   pfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   pfb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_opcode),
      .req_left_x       (req_left_x),
      .req_top_y        (req_top_y),
      .req_rect_width   (req_rect_width),
      .req_rect_height  (req_rect_height),
      .req_color        (req_color),
      .req_page_index   (req_page_index),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_is_command   (rsp_is_command),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_packed_bytes (rsp_packed_bytes),
      .rsp_last         (rsp_last)
   );

endmodule

### bench/tb_page_framebuffer_draw_and_scanout.sv
// testbench for the page frame buffer: drives draw and flush requests and checks every scanout word
`timescale 1ns / 1ps

module tb_page_framebuffer_draw_and_scanout;
   import pfb_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int STORE_BYTES    = COLUMNS * PAGES;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int SETTLE_CYCLES  = 300;
   localparam int PHASE_REQUESTS = 37;

   typedef struct {
      logic [1:0]         opcode;
      logic signed [15:0] left_x;
      logic signed [15:0] top_y;
      logic [7:0]         rect_width;
      logic [7:0]         rect_height;
      logic               color;
      logic [2:0]         page_index;
      int                 idle_pct;
      int                 stall_pct;
      bit                 drain;
   } draw_request_type;

   typedef struct {
      logic        is_command;
      logic [3:0]  byte_count;
      logic [63:0] packed_bytes;
      logic        last;
   } scan_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode = OP_FILL_RECT;
   logic signed [15:0] req_left_x = '0;
   logic signed [15:0] req_top_y = '0;
   logic [7:0]         req_rect_width = '0;
   logic [7:0]         req_rect_height = '0;
   logic               req_color = 1'b0;
   logic [2:0]         req_page_index = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_is_command;
   logic [3:0]         rsp_byte_count;
   logic [63:0]        rsp_packed_bytes;
   logic               rsp_last;

   draw_request_type draw_queue[$];
   draw_request_type in_flight;
   scan_word_type    scan_queue[$];
   scan_word_type    want_word;
   logic [7:0]       pixel_store [STORE_BYTES];

   int rsp_stall_pct = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int words_checked = 0;
   int rect_count = 0;
   int screen_count = 0;
   int flush_count = 0;
   int unused_count = 0;

   always #6 clock = ~clock;

   page_framebuffer_draw_and_scanout uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_left_x(req_left_x),
      .req_top_y(req_top_y),
      .req_rect_width(req_rect_width),
      .req_rect_height(req_rect_height),
      .req_color(req_color),
      .req_page_index(req_page_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_is_command(rsp_is_command),
      .rsp_byte_count(rsp_byte_count),
      .rsp_packed_bytes(rsp_packed_bytes),
      .rsp_last(rsp_last)
   );

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("[%0t] error: %s", $time, msg);
   endtask

   task automatic paint_rect(input int x, input int y, input int w, input int h,
                             input logic color);
      int x0, y0, x1, y1;
      x0 = (x < 0) ? 0 : x;
      y0 = (y < 0) ? 0 : y;
      x1 = (x + w > COLUMNS) ? COLUMNS : x + w;
      y1 = (y + h > ROWS) ? ROWS : y + h;
      for (int row = y0; row < y1; row++)
         for (int col = x0; col < x1; col++)
            pixel_store[(row >> 3) * COLUMNS + col][row & 7] = color;
   endtask

   task automatic queue_page_words(input int page);
      scan_word_type w;
      int n;
      if (page >= PAGES) return;
      w.is_command   = 1'b1;
      w.byte_count   = CMD_BYTES;
      w.packed_bytes = {40'd0, CMD_COL_HIGH, CMD_COL_LOW, CMD_PAGE_BASE + 8'(page)};
      w.last         = 1'b0;
      scan_queue.push_back(w);
      for (int col = 0; col < COLUMNS; col += 8) begin
         n = (COLUMNS - col > 8) ? 8 : COLUMNS - col;
         w.is_command   = 1'b0;
         w.byte_count   = 4'(n);
         w.packed_bytes = '0;
         for (int b = 0; b < n; b++)
            w.packed_bytes[8*b +: 8] = pixel_store[page * COLUMNS + col + b];
         w.last = (col + n >= COLUMNS);
         scan_queue.push_back(w);
      end
   endtask

   task automatic apply_request(input draw_request_type r);
      case (r.opcode)
         OP_FILL_RECT: begin
            rect_count++;
            paint_rect(int'(r.left_x), int'(r.top_y), int'(r.rect_width),
                       int'(r.rect_height), r.color);
         end
         OP_FILL_ALL: begin
            screen_count++;
            foreach (pixel_store[i]) pixel_store[i] = {8{r.color}};
         end
         OP_FLUSH: begin
            flush_count++;
            queue_page_words(int'(r.page_index));
         end
         default: unused_count++;
      endcase
   endtask

   task automatic add_request(input logic [1:0] op, input int x, input int y, input int w,
                              input int h, input int color, input int page,
                              input int idle, input int stall, input int drain);
      draw_request_type r;
      r.opcode      = op;
      r.left_x      = 16'(x);
      r.top_y       = 16'(y);
      r.rect_width  = 8'(w);
      r.rect_height = 8'(h);
      r.color       = 1'(color);
      r.page_index  = 3'(page);
      r.idle_pct    = idle;
      r.stall_pct   = stall;
      r.drain       = (drain != 0);
      draw_queue.push_back(r);
   endtask

   function automatic int pick_coord(input int span);
      case ($urandom_range(9))
         0, 1:    return int'($urandom_range(65535)) - 32768;
         2:       return span - 4 + int'($urandom_range(8));
         default: return int'($urandom_range(span + 80)) - 40;
      endcase
   endfunction

   function automatic int pick_size();
      case ($urandom_range(9))
         0:       return 0;
         1, 2:    return $urandom_range(255);
         default: return $urandom_range(1, 24);
      endcase
   endfunction

   always @(posedge clock) cycle_count <= cycle_count + 1;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) apply_request(in_flight);
         if (!req_valid || !req_stall) begin
            if (draw_queue.size() != 0 && $urandom_range(99) >= draw_queue[0].idle_pct &&
                !(draw_queue[0].drain && scan_queue.size() != 0)) begin
               in_flight = draw_queue.pop_front();
               req_valid       <= 1'b1;
               req_opcode      <= in_flight.opcode;
               req_left_x      <= in_flight.left_x;
               req_top_y       <= in_flight.top_y;
               req_rect_width  <= in_flight.rect_width;
               req_rect_height <= in_flight.rect_height;
               req_color       <= in_flight.color;
               req_page_index  <= in_flight.page_index;
               rsp_stall_pct   <= in_flight.stall_pct;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (scan_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected word cmd=%b count=%0d bytes=%h last=%b",
                  rsp_is_command, rsp_byte_count, rsp_packed_bytes, rsp_last));
            end else begin
               want_word = scan_queue.pop_front();
               words_checked++;
               if (rsp_is_command !== want_word.is_command)
                  report_mismatch($sformatf("is_command %b, want %b",
                     rsp_is_command, want_word.is_command));
               if (rsp_byte_count !== want_word.byte_count)
                  report_mismatch($sformatf("byte_count %0d, want %0d",
                     rsp_byte_count, want_word.byte_count));
               if (rsp_packed_bytes !== want_word.packed_bytes)
                  report_mismatch($sformatf("packed_bytes %h, want %h",
                     rsp_packed_bytes, want_word.packed_bytes));
               if (rsp_last !== want_word.last)
                  report_mismatch($sformatf("last %b, want %b", rsp_last, want_word.last));
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   initial begin
      int idle_tab[4];
      int stall_tab[4];
      int sel;
      logic [1:0] op;
      idle_tab  = '{0, 79, 0, 9};
      stall_tab = '{0, 0, 79, 9};
      foreach (pixel_store[i]) pixel_store[i] = 8'h00;

      // edges, clipping, empty rectangles and every opcode
      add_request(OP_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_request(OP_FILL_ALL, 0, 0, 0, 0, 1, 0, 0, 0, 0);
      add_request(OP_FLUSH, 0, 0, 0, 0, 0, 7, 0, 0, 0);
      add_request(OP_FILL_RECT, -32768, -32768, 255, 255, 0, 0, 0, 0, 0);
      add_request(OP_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_request(OP_FILL_RECT, -5, -3, 20, 12, 0, 0, 0, 0, 0);
      add_request(OP_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_request(OP_FLUSH, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      add_request(OP_FILL_RECT, 10, 10, 0, 50, 0, 0, 0, 0, 0);
      add_request(OP_FILL_RECT, 10, 10, 50, 0, 0, 0, 0, 0, 0);
      add_request(OP_FILL_RECT, 32767, 32767, 255, 255, 0, 0, 0, 0, 0);
      add_request(OP_FILL_RECT, 120, 60, 255, 255, 0, 0, 0, 0, 0);
      add_request(OP_FLUSH, 0, 0, 0, 0, 0, 7, 0, 0, 1);
      add_request(OP_UNUSED, 5, 6, 30, 30, 0, 7, 0, 0, 0);
      add_request(OP_FLUSH, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      add_request(OP_FILL_ALL, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_request(OP_FILL_RECT, 3, 5, 7, 9, 1, 0, 0, 0, 0);
      add_request(OP_FILL_RECT, 124, -2, 255, 11, 1, 0, 0, 0, 0);
      add_request(OP_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_request(OP_FLUSH, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      add_request(OP_FILL_RECT, -1, 63, 2, 1, 1, 0, 0, 0, 0);
      add_request(OP_FLUSH, 0, 0, 0, 0, 0, 7, 0, 0, 0);

      for (int p = 0; p < 4; p++) begin
         for (int k = 0; k < PHASE_REQUESTS; k++) begin
            sel = $urandom_range(99);
            if (sel < 45)      op = OP_FLUSH;
            else if (sel < 85) op = OP_FILL_RECT;
            else if (sel < 92) op = OP_FILL_ALL;
            else               op = OP_UNUSED;
            add_request(op, pick_coord(COLUMNS), pick_coord(ROWS), pick_size(), pick_size(),
                        $urandom_range(1), $urandom_range(7), idle_tab[p], stall_tab[p],
                        int'(k == 0));
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while ((draw_queue.size() != 0 || req_valid || scan_queue.size() != 0) &&
             cycle_count < CYCLE_LIMIT)
         @(posedge clock);

      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[%0t] error: run timed out after %0d cycles", $time, cycle_count);
         $display("Mismatches found");
      end else begin
         repeat (SETTLE_CYCLES) @(posedge clock);
         if (scan_queue.size() != 0)
            report_mismatch($sformatf("%0d scan words never arrived", scan_queue.size()));
         $display("checked %0d scan words from %0d flushes, %0d rectangle fills,",
                  words_checked, flush_count, rect_count);
         $display("%0d screen fills and %0d unused opcodes under four idle/stall mixes",
                  screen_count, unused_count);
         if (mismatches == 0) begin
            $display("No mismatches found");
         end else begin
            $display("Mismatches found");
         end
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/pfb_pkg.sv
hw/rtl/pfb_ram.sv
hw/rtl/pfb_datapath.sv
hw/rtl/pfb_ctrl.sv
hw/rtl/page_framebuffer_draw_and_scanout.sv
bench/tb_page_framebuffer_draw_and_scanout.sv
